// File: rtl/core/srfc_pkg.sv
// srfc_pkg: shared types, constants and helpers for the SAM record filter/counter.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`default_nettype none
package srfc_pkg;

  // Table geometry
  localparam int MAX_ENTRIES     = 128;
  localparam int MAX_INPUT_FILES = 8;
  localparam int NAME_BYTES      = 32;

  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int EU_W    = $clog2(MAX_ENTRIES + 1);
  localparam int NLEN_W  = $clog2(NAME_BYTES + 1);
  localparam int BUF_AW  = $clog2(NAME_BYTES);
  localparam int CNT_DEPTH = MAX_ENTRIES * MAX_INPUT_FILES;
  localparam int CNT_AW  = $clog2(CNT_DEPTH);

  // Port field widths
  localparam int ENTRY_W = 7;
  localparam int FILE_W  = 3;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [EU_W-1:0]    eu_t;
  typedef logic [NLEN_W-1:0]  nlen_t;
  typedef logic [CNT_AW-1:0]  cnt_addr_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [FILE_W-1:0]  file_t;

  // Field positions as counted by the tokenizer
  localparam logic [2:0] FLD_FEW   = 3'd2;
  localparam logic [2:0] FLD_FLAG  = 3'd2;
  localparam logic [2:0] FLD_RNAME = 3'd3;
  localparam logic [2:0] FLD_MAPQ  = 3'd5;
  localparam logic [2:0] FLD_CIGAR = 3'd6;
  localparam logic [2:0] FLD_CAP   = 3'd7;

  localparam int SECONDARY_BIT = 8;

  // Characters
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_X    = 8'h58;

  typedef enum logic [3:0] {
    ST_COUNTED     = 4'd0,
    ST_HEADER      = 4'd1,
    ST_FEW_FIELDS  = 4'd2,
    ST_SECONDARY   = 4'd3,
    ST_LOW_QUALITY = 4'd4,
    ST_SHORT       = 4'd5,
    ST_TABLE_FULL  = 4'd6,
    ST_ABANDONED   = 4'd7,
    ST_NAME_LONG   = 4'd8
  } status_t;

  typedef enum logic [0:0] {
    CFG_MIN_QUALITY = 1'b0,
    CFG_MIN_LENGTH  = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CLASSIFY,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_INSERT,
    S_COUNT_RD,
    S_COUNT_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    nlen_t                      len;
    logic [NAME_BYTES-1:0][7:0] name;
  } row_t;

  typedef struct packed {
    logic clear_step;
    logic take;
    logic cls_load;
    logic star_load;
    logic search_start;
    logic search_next;
    logic hit_load;
    logic full;
    logic insert;
    logic cnt_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic lookup;
    logic star;
    logic hit;
    logic search_last;
    logic table_full;
    logic out_free;
  } stat_t;

  function automatic row_t unmapped_row();
    row_t r;
    r = '0;
    r.name[0] = 8'h2A; r.name[1] = 8'h75; r.name[2] = 8'h6E; r.name[3] = 8'h6D;
    r.name[4] = 8'h61; r.name[5] = 8'h70; r.name[6] = 8'h70; r.name[7] = 8'h65;
    r.name[8] = 8'h64; r.name[9] = 8'h2A;
    r.len = nlen_t'(10);
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/srfc_text_if.sv
// srfc_text_if: input byte channel (valid/ready plus one SAM text byte).
// Depends on srfc_pkg for field types.
`default_nettype none
interface srfc_text_if;
  logic              valid;
  logic              ready;
  logic [7:0]        data_byte;
  logic              line_end;
  srfc_pkg::file_t   file_number;

  modport source (output valid, data_byte, line_end, file_number, input ready);
  modport sink   (input valid, data_byte, line_end, file_number, output ready);
endinterface
`default_nettype wire

// File: rtl/core/srfc_result_if.sv
// srfc_result_if: result channel, one beat per line end.
// Depends on srfc_pkg for field types.
`default_nettype none
interface srfc_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  srfc_pkg::entry_t   entry_index;
  srfc_pkg::file_t    result_file;
  logic [31:0]        new_count;

  modport source (output valid, status, entry_index, result_file, new_count, input ready);
  modport sink   (input valid, status, entry_index, result_file, new_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/srfc_cfg_if.sv
// srfc_cfg_if: configuration write channel (register index and data).
// Depends on srfc_pkg for the index type.
`default_nettype none
interface srfc_cfg_if;
  logic                   valid;
  logic                   ready;
  srfc_pkg::cfg_index_t   index;
  logic [30:0]            data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/srfc_ctrl.sv
// srfc_ctrl: sequencer for count clearing, line classification, name search and count update.
// Depends on srfc_pkg (state, command and status types).
`default_nettype none
module srfc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            text_valid,
  input  wire logic            text_line_end,
  output logic                 text_ready,
  input  wire srfc_pkg::stat_t stat,
  output srfc_pkg::cmd_t       cmd
);

  srfc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srfc_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    text_ready = 1'b0;
    case (state)
      srfc_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = srfc_pkg::S_IDLE;
      end
      srfc_pkg::S_IDLE: begin
        text_ready = 1'b1;
        if (text_valid) begin
          cmd.take = 1'b1;
          if (text_line_end) state_next = srfc_pkg::S_CLASSIFY;
        end
      end
      srfc_pkg::S_CLASSIFY: begin
        cmd.cls_load = 1'b1;
        if (!stat.lookup) begin
          state_next = srfc_pkg::S_DONE;
        end else if (stat.star) begin
          cmd.star_load = 1'b1;
          state_next    = srfc_pkg::S_COUNT_RD;
        end else begin
          cmd.search_start = 1'b1;
          state_next       = srfc_pkg::S_SEARCH_RD;
        end
      end
      srfc_pkg::S_SEARCH_RD: begin
        state_next = srfc_pkg::S_SEARCH_CMP;
      end
      srfc_pkg::S_SEARCH_CMP: begin
        if (stat.hit) begin
          cmd.hit_load = 1'b1;
          state_next   = srfc_pkg::S_COUNT_RD;
        end else if (stat.search_last) begin
          if (stat.table_full) begin
            cmd.full   = 1'b1;
            state_next = srfc_pkg::S_DONE;
          end else begin
            state_next = srfc_pkg::S_INSERT;
          end
        end else begin
          cmd.search_next = 1'b1;
          state_next      = srfc_pkg::S_SEARCH_RD;
        end
      end
      srfc_pkg::S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = srfc_pkg::S_COUNT_RD;
      end
      srfc_pkg::S_COUNT_RD: begin
        state_next = srfc_pkg::S_COUNT_WR;
      end
      srfc_pkg::S_COUNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_next = srfc_pkg::S_DONE;
      end
      srfc_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = srfc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = srfc_pkg::S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/srfc_dp.sv
// srfc_dp: line tokenizer, name table, count memory and result register.
// Depends on srfc_pkg and srfc_result_if; driven by commands from srfc_ctrl.
`default_nettype none
module srfc_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire srfc_pkg::cmd_t      cmd,
  output srfc_pkg::stat_t          stat,
  input  wire logic [7:0]          data_byte,
  input  wire logic                line_end,
  input  wire srfc_pkg::file_t     file_number,
  input  wire logic [7:0]          qual_floor,
  input  wire logic [30:0]         len_floor,
  srfc_result_if.source            result
);

  // Tokenizer state
  logic [2:0]  fp, fp_next;
  logic        in_token, in_token_next;
  logic        hdr, hdr_next;
  logic        started, started_next;
  logic        nopen, nopen_next;
  logic [31:0] flag, flag_next;
  logic [7:0]  qual, qual_next;
  logic [31:0] run, run_next;
  logic [31:0] rlen, rlen_next;
  srfc_pkg::nlen_t nlen, nlen_next;
  logic        abandoned, abandoned_next;
  srfc_pkg::file_t prev_file, prev_file_next;

  logic [srfc_pkg::NAME_BYTES-1:0][7:0] name_buf;
  logic                                 buf_we;
  logic [srfc_pkg::BUF_AW-1:0]          buf_wa;

  // Table and result state
  srfc_pkg::eu_t      entries_used;
  srfc_pkg::idx_t     search_i;
  srfc_pkg::row_t     name_mem [srfc_pkg::MAX_ENTRIES];
  srfc_pkg::row_t     name_q, row_cmp;
  logic [31:0]        cnt_mem [srfc_pkg::CNT_DEPTH];
  logic [31:0]        cnt_q, cnt_inc;
  srfc_pkg::cnt_addr_t clear_addr, slot;
  srfc_pkg::file_t    line_file;
  srfc_pkg::status_t  res_status, cls_status;
  srfc_pkg::idx_t     res_idx;
  logic [31:0]        res_cnt;
  logic               out_valid;
  logic               hit;
  logic               lookup;

  logic        dig;
  logic [3:0]  dval;
  logic [11:0] qw;
  logic [31:0] run_base;
  logic [35:0] rw;
  logic [32:0] sum;

  // Byte tokenizer
  always_comb begin
    fp_next        = fp;
    in_token_next  = in_token;
    hdr_next       = hdr;
    started_next   = started;
    nopen_next     = nopen;
    flag_next      = flag;
    qual_next      = qual;
    run_next       = run;
    rlen_next      = rlen;
    nlen_next      = nlen;
    abandoned_next = abandoned;
    prev_file_next = prev_file;
    buf_we         = 1'b0;
    buf_wa         = nlen[srfc_pkg::BUF_AW-1:0];
    dig      = (data_byte >= srfc_pkg::CH_0) && (data_byte <= srfc_pkg::CH_9);
    dval     = dig ? 4'(data_byte - srfc_pkg::CH_0) : 4'd0;
    qw       = '0;
    run_base = '0;
    rw       = '0;
    sum      = '0;

    if (cmd.out_load) begin
      fp_next = '0; in_token_next = 1'b0; hdr_next = 1'b0; started_next = 1'b0;
      nopen_next = 1'b0; flag_next = '0; qual_next = '0; run_next = '0;
      rlen_next = '0; nlen_next = '0;
    end

    if (cmd.take) begin
      if (file_number != prev_file) begin
        prev_file_next = file_number;
        abandoned_next = 1'b0;
        fp_next = '0; in_token_next = 1'b0; hdr_next = 1'b0; started_next = 1'b0;
        nopen_next = 1'b0; flag_next = '0; qual_next = '0; run_next = '0;
        rlen_next = '0; nlen_next = '0;
      end
      if (!(line_end && data_byte == srfc_pkg::CH_NL)) begin
        if (!started_next) begin
          started_next = 1'b1;
          hdr_next     = (data_byte == srfc_pkg::CH_AT);
        end
        if (data_byte == srfc_pkg::CH_TAB) begin
          in_token_next = 1'b0;
        end else begin
          if (!in_token_next) begin
            in_token_next = 1'b1;
            if (fp_next < srfc_pkg::FLD_CAP) fp_next = fp_next + 3'd1;
            nopen_next = (fp_next == srfc_pkg::FLD_FLAG) || (fp_next == srfc_pkg::FLD_MAPQ);
          end
          case (fp_next)
            srfc_pkg::FLD_FLAG: begin
              if (nopen_next && dig) flag_next = (flag_next << 3) + (flag_next << 1) + 32'(dval);
              else nopen_next = 1'b0;
            end
            srfc_pkg::FLD_RNAME: begin
              if (nlen_next < srfc_pkg::nlen_t'(srfc_pkg::NAME_BYTES)) begin
                buf_we    = 1'b1;
                buf_wa    = nlen_next[srfc_pkg::BUF_AW-1:0];
                nlen_next = nlen_next + 1'b1;
              end
            end
            srfc_pkg::FLD_MAPQ: begin
              if (nopen_next && dig) begin
                qw = ({4'd0, qual_next} << 3) + ({4'd0, qual_next} << 1) + 12'(dval);
                qual_next = (qw > 12'd255) ? 8'hFF : qw[7:0];
              end else begin
                nopen_next = 1'b0;
              end
            end
            srfc_pkg::FLD_CIGAR: begin
              if (dig) begin
                run_base   = nopen_next ? run_next : 32'd0;
                nopen_next = 1'b1;
                rw = ({4'd0, run_base} << 3) + ({4'd0, run_base} << 1) + 36'(dval);
                run_next = (rw[35:32] != 4'd0) ? 32'hFFFF_FFFF : rw[31:0];
              end else if (nopen_next) begin
                if (data_byte == srfc_pkg::CH_M || data_byte == srfc_pkg::CH_D ||
                    data_byte == srfc_pkg::CH_N || data_byte == srfc_pkg::CH_EQ ||
                    data_byte == srfc_pkg::CH_X) begin
                  sum       = {1'b0, rlen_next} + {1'b0, run_next};
                  rlen_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
                nopen_next = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end

    if (cmd.full) abandoned_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fp <= '0; in_token <= 1'b0; hdr <= 1'b0; started <= 1'b0; nopen <= 1'b0;
      flag <= '0; qual <= '0; run <= '0; rlen <= '0; nlen <= '0;
      abandoned <= 1'b0; prev_file <= '0;
    end else begin
      fp <= fp_next; in_token <= in_token_next; hdr <= hdr_next; started <= started_next;
      nopen <= nopen_next; flag <= flag_next; qual <= qual_next; run <= run_next;
      rlen <= rlen_next; nlen <= nlen_next;
      abandoned <= abandoned_next; prev_file <= prev_file_next;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) name_buf[buf_wa] <= data_byte;
    if (cmd.take) line_file <= file_number;
  end

  // Line classification, in priority order
  always_comb begin
    lookup = 1'b0;
    if (abandoned)                          cls_status = srfc_pkg::ST_ABANDONED;
    else if (hdr)                           cls_status = srfc_pkg::ST_HEADER;
    else if (fp < srfc_pkg::FLD_FEW)        cls_status = srfc_pkg::ST_FEW_FIELDS;
    else if (flag[srfc_pkg::SECONDARY_BIT]) cls_status = srfc_pkg::ST_SECONDARY;
    else if (fp < srfc_pkg::FLD_CIGAR)      cls_status = srfc_pkg::ST_FEW_FIELDS;
    else if (qual < qual_floor)             cls_status = srfc_pkg::ST_LOW_QUALITY;
    else if (rlen < {1'b0, len_floor})      cls_status = srfc_pkg::ST_SHORT;
    else if (nlen > srfc_pkg::nlen_t'(srfc_pkg::NAME_BYTES - 1))
                                            cls_status = srfc_pkg::ST_NAME_LONG;
    else begin
      cls_status = srfc_pkg::ST_COUNTED;
      lookup     = 1'b1;
    end
  end

  // Name table: one row per entry, entry 0 is the fixed unmapped name
  always_ff @(posedge clk) begin
    name_q <= name_mem[search_i];
    if (cmd.insert) begin
      name_mem[entries_used[srfc_pkg::IDX_W-1:0]] <= '{len: nlen, name: name_buf};
    end
  end

  assign row_cmp = (search_i == '0) ? srfc_pkg::unmapped_row() : name_q;

  always_comb begin
    hit = (row_cmp.len == nlen);
    for (int k = 0; k < srfc_pkg::NAME_BYTES; k++) begin
      if (srfc_pkg::nlen_t'(k) < nlen && row_cmp.name[k] != name_buf[k]) hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= srfc_pkg::eu_t'(1);
      search_i     <= '0;
    end else begin
      if (cmd.insert) entries_used <= entries_used + 1'b1;
      if (cmd.search_start) search_i <= '0;
      else if (cmd.search_next) search_i <= search_i + 1'b1;
    end
  end

  // Count memory: cleared after reset, one word per cycle
  assign slot    = srfc_pkg::cnt_addr_t'(res_idx * srfc_pkg::MAX_INPUT_FILES +
                                         line_file % srfc_pkg::MAX_INPUT_FILES);
  assign cnt_inc = (cnt_q == 32'hFFFF_FFFF) ? cnt_q : cnt_q + 32'd1;

  always_ff @(posedge clk) begin
    cnt_q <= cnt_mem[slot];
    if (cmd.clear_step) cnt_mem[clear_addr] <= '0;
    else if (cmd.cnt_wr) cnt_mem[slot] <= cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_step) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.cls_load) begin
      res_status <= cls_status;
      res_idx    <= '0;
      res_cnt    <= '0;
    end
    if (cmd.star_load) res_idx <= '0;
    if (cmd.hit_load) res_idx <= search_i;
    if (cmd.insert)   res_idx <= entries_used[srfc_pkg::IDX_W-1:0];
    if (cmd.full)     res_status <= srfc_pkg::ST_TABLE_FULL;
    if (cmd.cnt_wr)   res_cnt <= cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.status      <= res_status;
      result.entry_index <= srfc_pkg::entry_t'(res_idx);
      result.result_file <= line_file;
      result.new_count   <= res_cnt;
    end
  end

  assign result.valid     = out_valid;
  assign stat.lookup      = lookup;
  assign stat.clear_last  = (clear_addr == srfc_pkg::cnt_addr_t'(srfc_pkg::CNT_DEPTH - 1));
  assign stat.star        = (nlen == srfc_pkg::nlen_t'(1)) && (name_buf[0] == srfc_pkg::CH_STAR);
  assign stat.hit         = hit;
  assign stat.search_last = (srfc_pkg::eu_t'(search_i) + 1'b1 == entries_used);
  assign stat.table_full  = (entries_used >= srfc_pkg::eu_t'(srfc_pkg::MAX_ENTRIES));
  assign stat.out_free    = !out_valid || result.ready;

endmodule
`default_nettype wire

// File: rtl/core/sam_record_filter_counter.sv
// sam_record_filter_counter: top level of the SAM record filter and per-reference counter.
// Depends on srfc_pkg, the three channel interfaces, srfc_ctrl and srfc_dp.
//
//   channel | dir | beat carries                                   | when
//   text    | in  | data_byte, line_end, file_number               | one SAM byte
//   result  | out | status, entry_index, result_file, new_count    | one per line end
//   cfg     | in  | index (0 quality floor, 1 length floor), data  | register write
//
// A byte without line_end is taken whenever the sequencer is idle. A line end is first
// classified; when no lookup is needed its result is loaded directly, the unmapped name
// goes straight to the count update, and any other name is searched row by row (read, then
// compare) in the name memory, inserted if new and the table has room, then its count word is read and written.
// After reset the count memory is swept to zero, one word per cycle; text is held off
// meanwhile, configuration writes are always taken.
// A waiting result holds the line end in place; byte intake stalls until it is taken.
`default_nettype none
module sam_record_filter_counter (
  input  wire logic      clk,
  input  wire logic      rst,
  srfc_text_if.sink      text,
  srfc_result_if.source  result,
  srfc_cfg_if.sink       cfg
);

  srfc_pkg::cmd_t  cmd;
  srfc_pkg::stat_t stat;
  logic [7:0]      qual_floor;
  logic [30:0]     len_floor;

  // Configuration registers: always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      qual_floor <= '0;
      len_floor  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        srfc_pkg::CFG_MIN_QUALITY: qual_floor <= cfg.data[7:0];
        srfc_pkg::CFG_MIN_LENGTH:  len_floor  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  srfc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text.valid),
    .text_line_end (text.line_end),
    .text_ready    (text.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  srfc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .data_byte   (text.data_byte),
    .line_end    (text.line_end),
    .file_number (text.file_number),
    .qual_floor  (qual_floor),
    .len_floor   (len_floor),
    .result      (result)
  );

endmodule
`default_nettype wire

// File: bench/srfc_count_checker.sv
`timescale 1ns / 1ps
// srfc_count_checker: watches the text, result and config channels of the SAM record
// filter, predicts each line's classification and count, and compares. Needs srfc_pkg.
module srfc_count_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        txt_valid,
  input  logic        txt_ready,
  input  logic [7:0]  txt_byte,
  input  logic        txt_end,
  input  logic [2:0]  txt_file,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [3:0]  res_status,
  input  logic [6:0]  res_entry,
  input  logic [2:0]  res_file,
  input  logic [31:0] res_count,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  srfc_pkg::cfg_index_t cfg_index,
  input  logic [30:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [3:0]  status;
    logic [6:0]  entry;
    logic [2:0]  file;
    logic [31:0] count;
  } line_result_t;

  line_result_t expected_lines[$];

  logic [7:0]  qual_floor;
  logic [30:0] len_floor;
  int unsigned fld_pos;
  bit          in_tok, hdr, started, num_open;
  logic [31:0] flag_acc, run_num, ref_len;
  int unsigned qual_acc;
  logic [7:0]  name_buf[srfc_pkg::NAME_BYTES];
  int unsigned name_len;
  int unsigned used;
  logic [7:0]  names[srfc_pkg::MAX_ENTRIES][srfc_pkg::NAME_BYTES];
  int unsigned name_lens[srfc_pkg::MAX_ENTRIES];
  logic [31:0] counts[srfc_pkg::MAX_ENTRIES * srfc_pkg::MAX_INPUT_FILES];
  bit          abandoned;
  logic [2:0]  prev_file;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic clear_line();
    fld_pos = 0; in_tok = 0; hdr = 0; started = 0; num_open = 0;
    flag_acc = 0; qual_acc = 0; run_num = 0; ref_len = 0; name_len = 0;
  endtask

  task automatic parse_byte(logic [7:0] b);
    bit dig;
    logic [63:0] v;
    dig = b >= srfc_pkg::CH_0 && b <= srfc_pkg::CH_9;
    if (!started) begin
      started = 1;
      hdr = (b == srfc_pkg::CH_AT);
    end
    if (b == srfc_pkg::CH_TAB) begin
      in_tok = 0;
      return;
    end
    if (!in_tok) begin
      in_tok = 1;
      if (fld_pos < 7) fld_pos++;
      num_open = (fld_pos == 2 || fld_pos == 5);
    end
    case (fld_pos)
      2: if (num_open && dig) flag_acc = flag_acc * 10 + (b - srfc_pkg::CH_0);
         else num_open = 0;
      3: if (name_len < srfc_pkg::NAME_BYTES) begin
        name_buf[name_len] = b;
        name_len++;
      end
      5: if (num_open && dig) begin
        qual_acc = qual_acc * 10 + (b - srfc_pkg::CH_0);
        if (qual_acc > 255) qual_acc = 255;
      end else num_open = 0;
      6: if (dig) begin
        if (!num_open) run_num = 0;
        num_open = 1;
        v = 64'(run_num) * 10 + (b - srfc_pkg::CH_0);
        run_num = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      end else if (num_open) begin
        if (b == srfc_pkg::CH_M || b == srfc_pkg::CH_D || b == srfc_pkg::CH_N ||
            b == srfc_pkg::CH_EQ || b == srfc_pkg::CH_X)
          ref_len = sat_add(ref_len, run_num);
        num_open = 0;
      end
      default: ;
    endcase
  endtask

  // Classify the finished line and update the name and count tables.
  function automatic line_result_t classify_line(logic [2:0] f);
    line_result_t r;
    bit found, same;
    int unsigned slot;
    r = '0;
    r.file = f;
    if (abandoned) r.status = srfc_pkg::ST_ABANDONED;
    else if (hdr) r.status = srfc_pkg::ST_HEADER;
    else if (fld_pos < 2) r.status = srfc_pkg::ST_FEW_FIELDS;
    else if (flag_acc[srfc_pkg::SECONDARY_BIT]) r.status = srfc_pkg::ST_SECONDARY;
    else if (fld_pos < 6) r.status = srfc_pkg::ST_FEW_FIELDS;
    else if (qual_acc < qual_floor) r.status = srfc_pkg::ST_LOW_QUALITY;
    else if (ref_len < {1'b0, len_floor}) r.status = srfc_pkg::ST_SHORT;
    else if (name_len > srfc_pkg::NAME_BYTES - 1) r.status = srfc_pkg::ST_NAME_LONG;
    else begin
      found = (name_len == 1 && name_buf[0] == srfc_pkg::CH_STAR);
      for (int i = 0; !found && i < used; i++) begin
        same = (name_lens[i] == name_len);
        for (int k = 0; same && k < name_len; k++)
          if (names[i][k] != name_buf[k]) same = 0;
        if (same) begin
          found = 1;
          r.entry = 7'(i);
        end
      end
      if (!found) begin
        if (used >= srfc_pkg::MAX_ENTRIES) begin
          r.status = srfc_pkg::ST_TABLE_FULL;
          abandoned = 1;
        end else begin
          r.entry = 7'(used);
          for (int k = 0; k < name_len; k++) names[used][k] = name_buf[k];
          name_lens[used] = name_len;
          used++;
          found = 1;
        end
      end
      if (found) begin
        r.status = srfc_pkg::ST_COUNTED;
        slot = r.entry * srfc_pkg::MAX_INPUT_FILES + f;
        if (counts[slot] != 32'hFFFF_FFFF) counts[slot]++;
        r.count = counts[slot];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    logic [7:0] unm[10];
    unm = '{8'h2A, 8'h75, 8'h6E, 8'h6D, 8'h61, 8'h70, 8'h70, 8'h65, 8'h64, 8'h2A};
    fail_count = 0;
    pending = 0;
    qual_floor = 0; len_floor = 0; used = 1; abandoned = 0; prev_file = 0;
    clear_line();
    for (int k = 0; k < 10; k++) names[0][k] = unm[k];
    name_lens[0] = 10;
    foreach (counts[i]) counts[i] = 0;
  end

  always @(posedge clk) begin
    line_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == srfc_pkg::CFG_MIN_QUALITY) qual_floor = cfg_data[7:0];
        else len_floor = cfg_data;
      end
      if (res_valid && res_ready) begin
        if (expected_lines.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(res_status), 0);
        end else begin
          want = expected_lines.pop_front();
          if (res_status != want.status)
            report_mismatch("status", 32'(res_status), 32'(want.status));
          if (res_entry != want.entry)
            report_mismatch("entry_index", 32'(res_entry), 32'(want.entry));
          if (res_file != want.file)
            report_mismatch("result_file", 32'(res_file), 32'(want.file));
          if (res_count != want.count) report_mismatch("new_count", res_count, want.count);
        end
      end
      if (txt_valid && txt_ready) begin
        if (txt_file != prev_file) begin
          prev_file = txt_file;
          abandoned = 0;
          clear_line();
        end
        if (!(txt_end && txt_byte == srfc_pkg::CH_NL)) parse_byte(txt_byte);
        if (txt_end) begin
          expected_lines.push_back(classify_line(txt_file));
          clear_line();
        end
      end
      pending = expected_lines.size();
    end
  end
endmodule

// File: bench/tb_sam_record_filter_counter.sv
`timescale 1ns / 1ps
// tb_sam_record_filter_counter: drives SAM text lines and config writes into the filter,
// with random idling on both sides. Needs srfc_pkg, the channel interfaces and the checker.
module tb_sam_record_filter_counter;

  logic clk = 0;
  logic rst = 1;
  always #1 clk = ~clk;

  srfc_text_if   text();
  srfc_result_if result();
  srfc_cfg_if    cfg();

  int fail_count, pending;
  int send_idle_pct, recv_idle_pct;
  bit hold_off;
  int beats_sent;

  sam_record_filter_counter u_dut (
    .clk(clk), .rst(rst), .text(text.sink), .result(result.source), .cfg(cfg.sink)
  );

  srfc_count_checker u_checker (
    .clk(clk), .rst(rst),
    .txt_valid(text.valid), .txt_ready(text.ready), .txt_byte(text.data_byte),
    .txt_end(text.line_end), .txt_file(text.file_number),
    .res_valid(result.valid), .res_ready(result.ready), .res_status(result.status),
    .res_entry(result.entry_index), .res_file(result.result_file),
    .res_count(result.new_count),
    .cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_index(cfg.index),
    .cfg_data(cfg.data),
    .fail_count(fail_count), .pending(pending)
  );

  // Line text built by the generators, streamed one beat per byte.
  byte unsigned line_buf[$];
  logic [2:0] cur_file;

  initial begin
    text.valid = 0; text.data_byte = 0; text.line_end = 0; text.file_number = 0;
    result.ready = 0;
    cfg.valid = 0; cfg.index = srfc_pkg::CFG_MIN_QUALITY; cfg.data = 0;
  end

  // Receiver: random ready; a hold-off forces ready low for a long stretch.
  always @(posedge clk) begin
    if (rst) result.ready <= 0;
    else if (hold_off) result.ready <= 0;
    else result.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hold off the receiver for a long count of cycles while text is still offered.
  task automatic long_hold_off();
    hold_off = 1;
    repeat (3000) @(posedge clk);
    hold_off = 0;
  endtask

  // Send one beat; the last byte of a line carries line_end.
  task automatic send_beat(byte unsigned b, bit last, logic [2:0] f);
    while ($urandom_range(99) < send_idle_pct) begin
      text.valid <= 0;
      @(posedge clk);
    end
    text.valid <= 1;
    text.data_byte <= b;
    text.line_end <= last;
    text.file_number <= f;
    @(posedge clk);
    while (!text.ready) @(posedge clk);
    beats_sent++;
  endtask

  // Stream line_buf; end with a newline marked as line end, or mark the last byte.
  task automatic send_line(bit nl_end);
    if (nl_end || line_buf.size() == 0) line_buf.push_back(8'h0A);
    foreach (line_buf[i]) send_beat(line_buf[i], i == line_buf.size() - 1, cur_file);
    line_buf.delete();
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Build one alignment record; the name picks from a pool to get repeats.
  task automatic build_record(int name_pool, bit long_name);
    int n;
    push_text("r1\t");
    if ($urandom_range(3) == 0) push_text($sformatf("%0d", $urandom_range(300)));
    else push_text($sformatf("%0d", $urandom_range(1) ? 0 : 16));
    push_text("\t");
    n = $urandom_range(name_pool);
    if (long_name) push_text("chr_abcdefghijklmnopqrstuvwxyz0123");
    else if (n == 0) push_text("*");
    else push_text($sformatf("chr%0d", n));
    push_text($sformatf("\t%0d\t%0d\t", $urandom_range(100000), $urandom_range(300)));
    repeat ($urandom_range(3)) begin
      push_text($sformatf("%0d", $urandom_range(120)));
      case ($urandom_range(8))
        0: push_text("M"); 1: push_text("D"); 2: push_text("N"); 3: push_text("=");
        4: push_text("X"); 5: push_text("I"); 6: push_text("S"); default: push_text("M");
      endcase
    end
    if ($urandom_range(1)) push_text("\t*\t0\t0\tACGT");
  endtask

  task automatic write_reg(srfc_pkg::cfg_index_t idx, logic [30:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
  endtask

  // Drain all expected results, then let the line-end pipeline settle.
  task automatic drain();
    text.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Random phase: mostly well-formed records, some noise, some file changes.
  task automatic random_phase(int beats, int pool);
    int stop;
    stop = beats_sent + beats;
    while (beats_sent < stop) begin
      case ($urandom_range(19))
        0: begin
          push_text("@SQ\tSN:chr1");
          send_line(1);
        end
        1: begin
          repeat ($urandom_range(6)) line_buf.push_back(8'($urandom_range(255)));
          send_line($urandom_range(1));
        end
        2: begin
          cur_file = 3'($urandom_range(7));
          build_record(pool, 0);
          send_line(1);
        end
        3: begin
          build_record(pool, $urandom_range(1));
          repeat ($urandom_range(4)) send_beat(line_buf.pop_front(), 0, cur_file);
          cur_file = cur_file + 3'd1;
          send_line(1);
        end
        default: begin
          build_record(pool, 0);
          send_line($urandom_range(3) != 0);
        end
      endcase
    end
  endtask

  initial begin
    send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0; beats_sent = 0; cur_file = 0;
    repeat (7) @(posedge clk);
    rst <= 0;

    // Directed: header, empty, few fields, secondary, star name, long name, FLAG overflow,
    // MAPQ and CIGAR saturation, zero bytes, and a line whose last byte is content.
    push_text("@HD\tVN:1.6"); send_line(1);
    send_line(1);
    push_text("r0\t0\tchrA"); send_line(1);
    push_text("r0\t256\tchrA\t1\t60\t10M"); send_line(1);
    push_text("r0\t\t\t0\t\t*\t5\t255\t4M2I3D1N2=1X5S"); send_line(1);
    push_text("r0\t99999999999\tchrB\t1\t99999\t4294967299M9M"); send_line(0);
    push_text("r0\t0\tchr_abcdefghijklmnopqrstuvwxyz0123\t1\t9\t5M"); send_line(1);
    push_text("r0\t+4\tchrC\t1\t-3\t12M3"); line_buf.push_back(0); send_line(0);
    push_text("r0\t0\tchrA\t1\t60\t10M"); send_line(1);
    drain();
    write_reg(srfc_pkg::CFG_MIN_QUALITY, 31'd255);
    write_reg(srfc_pkg::CFG_MIN_LENGTH, 31'h7FFF_FFFF);
    push_text("r0\t0\tchrA\t1\t254\t10M"); send_line(1);
    push_text("r0\t0\tchrA\t1\t255\t10M"); send_line(1);
    drain();
    write_reg(srfc_pkg::CFG_MIN_QUALITY, 31'd30);
    write_reg(srfc_pkg::CFG_MIN_LENGTH, 31'd50);

    // Phase 1: sender idles often, receiver idles more; small name pool.
    send_idle_pct = 38; recv_idle_pct = 84;
    random_phase(450, 40);
    drain();
    write_reg(srfc_pkg::CFG_MIN_QUALITY, 31'd0);
    write_reg(srfc_pkg::CFG_MIN_LENGTH, 31'd0);

    // Phase 2: roles swapped; a large name pool, starting in file 5.
    send_idle_pct = 84; recv_idle_pct = 38;
    cur_file = 5;
    random_phase(450, 400);
    drain();
    write_reg(srfc_pkg::CFG_MIN_QUALITY, 31'd10);
    write_reg(srfc_pkg::CFG_MIN_LENGTH, 31'd20);

    // Phase 3: no idling, with a long receiver hold-off so the input stalls.
    send_idle_pct = 0; recv_idle_pct = 0;
    fork
      long_hold_off();
      random_phase(450, 200);
    join
    drain();

    if (fail_count == 0) $display("tb_sam_record_filter_counter passed");
    else $display("tb_sam_record_filter_counter failed");
    $finish;
  end

  // Timeout guard.
  initial begin
    #40ms;
    $display("tb_sam_record_filter_counter failed");
    $finish;
  end
endmodule

// File: sam_record_filter_counter.f
rtl/core/srfc_pkg.sv
rtl/core/srfc_text_if.sv
rtl/core/srfc_result_if.sv
rtl/core/srfc_cfg_if.sv
rtl/core/srfc_ctrl.sv
rtl/core/srfc_dp.sv
rtl/core/sam_record_filter_counter.sv
bench/srfc_count_checker.sv
bench/tb_sam_record_filter_counter.sv
